// File: sv/tcp8_pkg.sv
// package: item types, codes and action helpers for the 8-bit timer/counter
`timescale 1ns / 1ps
`default_nettype none
package tcp8_pkg;

  localparam int PRESCALE_BITS = 10;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [2:0] REG_CTRL  = 3'd0;
  localparam logic [2:0] REG_COUNT = 3'd1;
  localparam logic [2:0] REG_CMP   = 3'd2;
  localparam logic [2:0] REG_MASK  = 3'd3;
  localparam logic [2:0] REG_FLAGS = 3'd4;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_PHASE  = 2'd1;
  localparam logic [1:0] MODE_CTC    = 2'd2;
  localparam logic [1:0] MODE_FAST   = 2'd3;

  localparam logic [1:0] COM_OFF    = 2'd0;
  localparam logic [1:0] COM_TOGGLE = 2'd1;
  localparam logic [1:0] COM_CLEAR  = 2'd2;
  localparam logic [1:0] COM_SET    = 2'd3;

  localparam logic [2:0] CS_STOP  = 3'd0;
  localparam logic [2:0] CS_DIV1  = 3'd1;
  localparam logic [2:0] CS_DIV8  = 3'd2;
  localparam logic [2:0] CS_DIV64 = 3'd3;
  localparam logic [2:0] CS_DIV256  = 3'd4;
  localparam logic [2:0] CS_DIV1024 = 3'd5;
  localparam logic [2:0] CS_PIN_FALL = 3'd6;
  localparam logic [2:0] CS_PIN_RISE = 3'd7;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic       ext_pin;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       compare_out;
    logic       overflow_irq;
    logic       compare_irq;
    logic [7:0] count_now;
  } out_item_t;

  // non-pwm match action
  function automatic logic plain_act(input logic [1:0] com, input logic lvl);
    logic res;
    res = lvl;
    case (com)
      COM_TOGGLE: res = ~lvl;
      COM_CLEAR:  res = 1'b0;
      COM_SET:    res = 1'b1;
      default:    res = lvl;
    endcase
    return res;
  endfunction

  // pwm level on the first-side or second-side event
  function automatic logic pwm_lvl(input logic [1:0] com, input logic first,
                                   input logic lvl);
    logic res;
    res = lvl;
    case (com)
      COM_CLEAR: res = ~first;
      COM_SET:   res = first;
      default:   res = lvl;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// File: sv/tcp8_core.sv
// timer state registers and the single-pass next-state and result logic
`timescale 1ns / 1ps
`default_nettype none
module tcp8_core
  import tcp8_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      accept,
  input  wire in_item_t  item,
  output out_item_t      result
);

  logic [PRESCALE_BITS-1:0] psc_r, psc_nxt;
  logic       pin_r, pin_nxt;
  logic [6:0] ctrl_r, ctrl_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] ocr_r, ocr_nxt;
  logic [7:0] ocrb_r, ocrb_nxt;
  logic       down_r, down_nxt;
  logic       lvl_r, lvl_nxt;
  logic [1:0] mask_r, mask_nxt;
  logic [1:0] flag_r, flag_nxt;

  logic [1:0] mode;
  logic [1:0] com;
  logic [1:0] wr_mode;
  logic       match;
  logic       fire;
  logic       up;
  logic [7:0] rd;
  logic [1:0] com_n;
  logic       connected;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psc_r  <= '0;
      pin_r  <= 1'b0;
      ctrl_r <= '0;
      cnt_r  <= '0;
      ocr_r  <= '0;
      ocrb_r <= '0;
      down_r <= 1'b0;
      lvl_r  <= 1'b0;
      mask_r <= '0;
      flag_r <= '0;
    end else if (accept) begin
      psc_r  <= psc_nxt;
      pin_r  <= pin_nxt;
      ctrl_r <= ctrl_nxt;
      cnt_r  <= cnt_nxt;
      ocr_r  <= ocr_nxt;
      ocrb_r <= ocrb_nxt;
      down_r <= down_nxt;
      lvl_r  <= lvl_nxt;
      mask_r <= mask_nxt;
      flag_r <= flag_nxt;
    end
  end

  always_comb begin
    psc_nxt  = psc_r;
    pin_nxt  = pin_r;
    ctrl_nxt = ctrl_r;
    cnt_nxt  = cnt_r;
    ocr_nxt  = ocr_r;
    ocrb_nxt = ocrb_r;
    down_nxt = down_r;
    lvl_nxt  = lvl_r;
    mask_nxt = mask_r;
    flag_nxt = flag_r;
    rd       = 8'd0;
    fire     = 1'b0;
    up       = 1'b0;
    mode     = {ctrl_r[3], ctrl_r[6]};
    com      = ctrl_r[5:4];
    wr_mode  = {item.write_data[3], item.write_data[6]};
    match    = (cnt_r == ocr_r);

    case (item.req_type)
      REQ_TICK: begin
        psc_nxt = psc_r + PRESCALE_BITS'(1);
        pin_nxt = item.ext_pin;
        case (ctrl_r[2:0])
          CS_DIV1:     fire = 1'b1;
          CS_DIV8:     fire = (psc_nxt[2:0] == '0);
          CS_DIV64:    fire = (psc_nxt[5:0] == '0);
          CS_DIV256:   fire = (psc_nxt[7:0] == '0);
          CS_DIV1024:  fire = (psc_nxt[9:0] == '0);
          CS_PIN_FALL: fire = pin_r & ~item.ext_pin;
          CS_PIN_RISE: fire = ~pin_r & item.ext_pin;
          default:     fire = 1'b0;
        endcase
        if (fire) begin
          case (mode)
            MODE_NORMAL, MODE_CTC: begin
              if (match) begin
                flag_nxt[1] = 1'b1;
                lvl_nxt = plain_act(com, lvl_r);
              end
              if (mode == MODE_CTC && match) cnt_nxt = 8'd0;
              else cnt_nxt = cnt_r + 8'd1;
              if (cnt_r == 8'hFF) flag_nxt[0] = 1'b1;
            end
            MODE_FAST: begin
              if (match) begin
                flag_nxt[1] = 1'b1;
                lvl_nxt = pwm_lvl(com, 1'b1, lvl_r);
              end
              cnt_nxt = cnt_r + 8'd1;
              if (cnt_r == 8'hFF) begin
                flag_nxt[0] = 1'b1;
                ocr_nxt = ocrb_r;
                lvl_nxt = pwm_lvl(com, 1'b0, lvl_r);
              end
            end
            default: begin
              if (match) begin
                flag_nxt[1] = 1'b1;
                if (cnt_r == 8'd0) up = 1'b1;
                else if (cnt_r == 8'hFF) up = 1'b0;
                else up = ~down_r;
                lvl_nxt = pwm_lvl(com, up, lvl_r);
              end
              if (!down_r) begin
                if (cnt_r == 8'hFF) begin
                  down_nxt = 1'b1;
                  cnt_nxt = 8'hFE;
                end else begin
                  cnt_nxt = cnt_r + 8'd1;
                  if (cnt_r == 8'hFE) ocr_nxt = ocrb_r;
                end
              end else begin
                if (cnt_r == 8'd0) begin
                  down_nxt = 1'b0;
                  cnt_nxt = 8'd1;
                end else begin
                  cnt_nxt = cnt_r - 8'd1;
                  if (cnt_r == 8'd1) flag_nxt[0] = 1'b1;
                end
              end
            end
          endcase
        end
      end
      REQ_WRITE: begin
        case (item.reg_select)
          REG_CTRL: begin
            ctrl_nxt = item.write_data[6:0];
            if (wr_mode != MODE_PHASE) down_nxt = 1'b0;
            if (!wr_mode[0]) begin
              ocr_nxt = ocrb_r;
              if (item.write_data[7]) lvl_nxt = plain_act(item.write_data[5:4], lvl_r);
            end
          end
          REG_COUNT: cnt_nxt = item.write_data;
          REG_CMP: begin
            ocrb_nxt = item.write_data;
            if (!mode[0]) ocr_nxt = item.write_data;
          end
          REG_MASK:  mask_nxt = item.write_data[1:0];
          REG_FLAGS: flag_nxt = flag_r & ~item.write_data[1:0];
          default: ;
        endcase
      end
      REQ_READ: begin
        case (item.reg_select)
          REG_CTRL:  rd = {1'b0, ctrl_r};
          REG_COUNT: rd = cnt_r;
          REG_CMP:   rd = ocrb_r;
          REG_MASK:  rd = {6'd0, mask_r};
          REG_FLAGS: rd = {6'd0, flag_r};
          default:   rd = 8'd0;
        endcase
      end
      default: ;
    endcase

    com_n     = ctrl_nxt[5:4];
    connected = (com_n != COM_OFF) && !(ctrl_nxt[6] && com_n == COM_TOGGLE);

    result.read_data    = rd;
    result.compare_out  = connected & lvl_nxt;
    result.overflow_irq = flag_nxt[0] & mask_nxt[0];
    result.compare_irq  = flag_nxt[1] & mask_nxt[1];
    result.count_now    = cnt_nxt;
  end

endmodule
`default_nettype wire

// File: sv/timer_counter_pwm_8bit.sv
// top level: 8-bit timer/counter with compare output, item handshake and skid stage
//
//   channel   ports                     payload
//   input     in_valid / in_ready       in_item  (in_item_t)
//   result    out_valid / out_ready     out_item (out_item_t)
//
// one item per cycle while in_ready is high; each item's result appears in the output
// register on the cycle after it is accepted, or in the skid register if the output is stalled
// the state update and result come from one pass of logic in the core
// a skid register holds one result while out_ready is low, so in_ready
// drops only when both output and skid registers are full
// rst_n is synchronous and clears all timer state and both valid bits
`timescale 1ns / 1ps
`default_nettype none
module timer_counter_pwm_8bit
  import tcp8_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic      accept;
  out_item_t result;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      skid_valid_r;
  out_item_t skid_data_r;

  assign in_ready = ~skid_valid_r;
  assign accept   = in_valid & in_ready;

  tcp8_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
        out_data_r  <= result;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
      skid_data_r  <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

endmodule
`default_nettype wire

// File: sv/tcp8_checker.sv
// port-level checks for the timer/counter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module tcp8_checker
  import tcp8_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  // nothing left over from before reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("result pending right after reset");

  // input stalls only while a result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && $past(out_valid && !out_ready))
    else $error("in_ready low without a held result");

  // out_valid is always high in the cycle after an item is accepted
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  // held result does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

endmodule

bind timer_counter_pwm_8bit tcp8_checker u_tcp8_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
